// ===== design/assert_macros.svh =====
// Assertion macros shared by the delay line modules.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== design/fdl_pkg.sv =====
`timescale 1ns / 1ps
// Package of the fractional delay line: command codes, queue item type, states.
// No dependencies.
package fdl_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_CLEAR
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] sample;
    logic [15:0]        index;
    logic [15:0]        frac;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_COEF,
    S_MUL1,
    S_ADD1,
    S_MUL2,
    S_ADD2,
    S_MUL3,
    S_OUT
  } state_e;

endpackage

// ===== design/fdl_front.sv =====
`timescale 1ns / 1ps
// Input side of the delay line: takes stream transfers and decodes the command.
// Depends on fdl_pkg.
module fdl_front import fdl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [47:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic cmd_ok;
  kind_e kind;
  logic seen_q;

  always_comb begin
    cmd_ok = 1'b1;
    kind   = KIND_WRITE;
    unique case (s_tuser_i)
      CMD_WRITE: kind = KIND_WRITE;
      CMD_READ:  kind = KIND_READ;
      CMD_CLEAR: kind = KIND_CLEAR;
      default:   cmd_ok = 1'b0;
    endcase
  end

  // Transfers are taken only once reset has been released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= 1'b1;
    end
  end

  assign s_tready_o    = seen_q && !full_i;
  assign push_o        = s_tvalid_i && s_tready_o && cmd_ok;
  assign item_o.kind   = kind;
  assign item_o.sample = s_tdata_i[15:0];
  assign item_o.index  = s_tdata_i[31:16];
  assign item_o.frac   = s_tdata_i[47:32];

endmodule

// ===== design/fdl_fifo.sv =====
`timescale 1ns / 1ps
// Short item queue between the decoder and the execution unit.
// Depends on fdl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fdl_fifo import fdl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "queue push while full")
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o, "queue pop while empty")

endmodule

// ===== design/fdl_back.sv =====
`timescale 1ns / 1ps
// Execution unit of the delay line: sample store, four-tap fetch, cubic
// interpolation on one shared multiplier and the output register.
// Depends on fdl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fdl_back import fdl_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = AW + 1;
  localparam logic [2:0] LastTap = 3'd4;

  logic [15:0]        mem_q [DEPTH];
  logic [15:0]        rd_data_q;
  logic               rd_ok_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;

  state_e             state_q, state_d;
  logic [AW-1:0]      wp_q, wp_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [AW-1:0]      base_q, base_d;
  logic [15:0]        frac_q, frac_d;
  logic [2:0]         rcnt_q, rcnt_d;
  logic [1:0]         hidx;

  logic signed [15:0] h_q [4];
  logic signed [17:0] c1_q;
  logic signed [19:0] c2_q, c3_q, c3_diff;
  logic signed [37:0] inner_q;
  logic signed [39:0] midr_q;
  logic signed [39:0] mul_a;
  logic signed [56:0] prod_q, prod_d;
  logic signed [56:0] mid_w, midr_full, acc_w, delta_full;
  logic signed [23:0] delta_w;
  logic signed [24:0] y_w;
  logic [15:0]        y_sat;

  logic               load_out;
  logic               out_valid_q;
  logic [15:0]        out_data_q;

  // Only entries below the fill count were written since the last clear.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= item_i.sample;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
      rd_ok_q   <= ({1'b0, mem_addr} < fill_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    base_d     = base_q;
    frac_d     = frac_q;
    rcnt_d     = rcnt_q;
    item_pop_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = wp_q;
    mul_a      = '0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          unique case (item_i.kind)
            KIND_WRITE: begin
              mem_we = 1'b1;
              wp_d   = wp_q + 1'b1;
              if (fill_q != FW'(DEPTH)) begin
                fill_d = fill_q + 1'b1;
              end
            end
            KIND_CLEAR: begin
              wp_d   = '0;
              fill_d = '0;
            end
            KIND_READ: begin
              base_d  = item_i.index[AW-1:0];
              frac_d  = item_i.frac;
              rcnt_d  = '0;
              state_d = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        mem_re   = !rcnt_q[2];
        mem_addr = base_q + AW'(rcnt_q[1:0]) - AW'(1);
        rcnt_d   = rcnt_q + 1'b1;
        if (rcnt_q == LastTap) begin
          state_d = S_COEF;
        end
      end
      S_COEF: state_d = S_MUL1;
      S_MUL1: begin
        mul_a   = 40'(c3_q);
        state_d = S_ADD1;
      end
      S_ADD1: state_d = S_MUL2;
      S_MUL2: begin
        mul_a   = 40'(inner_q);
        state_d = S_ADD2;
      end
      S_ADD2: state_d = S_MUL3;
      S_MUL3: begin
        mul_a   = midr_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    hidx       = 2'(rcnt_q - 3'd1);
    c3_diff    = 20'(h_q[1]) - 20'(h_q[2]);
    prod_d     = mul_a * $signed({1'b0, frac_q});
    mid_w      = (57'(c1_q) <<< 32) + prod_q + 57'(32768);
    midr_full  = mid_w >>> 16;
    acc_w      = prod_q + (57'(1) <<< 32);
    delta_full = acc_w >>> 33;
    delta_w    = delta_full[23:0];
    y_w        = 25'(h_q[1]) + 25'(delta_w);
    if (y_w > 25'sd32767) begin
      y_sat = 16'h7fff;
    end else if (y_w < -25'sd32768) begin
      y_sat = 16'h8000;
    end else begin
      y_sat = y_w[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      rcnt_q  <= rcnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    frac_q <= frac_d;
    if (state_q == S_READ && rcnt_q != 3'd0) begin
      h_q[hidx] <= rd_ok_q ? $signed(rd_data_q) : 16'sd0;
    end
    if (state_q == S_COEF) begin
      c1_q <= 18'(h_q[2]) - 18'(h_q[0]);
      c2_q <= (20'(h_q[0]) <<< 1) - (20'(h_q[1]) <<< 2) - 20'(h_q[1])
            + (20'(h_q[2]) <<< 2) - 20'(h_q[3]);
      c3_q <= (c3_diff <<< 1) + c3_diff + 20'(h_q[3]) - 20'(h_q[0]);
    end
    if (state_q == S_MUL1 || state_q == S_MUL2 || state_q == S_MUL3) begin
      prod_q <= prod_d;
    end
    if (state_q == S_ADD1) begin
      inner_q <= (38'(c2_q) <<< 16) + 38'(prod_q);
    end
    if (state_q == S_ADD2) begin
      midr_q <= midr_full[39:0];
    end
    if (load_out) begin
      out_data_q <= y_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > FW'(DEPTH), "fill count beyond depth")
  `ASSERT_AT(a_wp_tracks_fill, clk_i, rst_ni,
             (fill_q != FW'(DEPTH)) |-> ({1'b0, wp_q} == fill_q),
             "write pointer and fill count disagree")

endmodule

// ===== design/fractional_delay_line_cubic.sv =====
`timescale 1ns / 1ps
// Fractional delay line with Catmull-Rom cubic interpolation.
// Input side: stream slave. tuser carries the command (0 write, 1 interpolated
// read, 2 clear); other codes are accepted and dropped. tdata carries, from
// bit 0 up, sample_in[15:0], read_index[31:16] and read_fraction[47:32].
// Output side: stream master, tdata holds sample_out, one transfer per read.
// A four-entry queue sits between the decoder and the execution unit, so
// transfers are taken while the unit works or a result waits for the receiver.
// Writes and clears are done in the unit as they leave the queue. A read
// passes four fetches through the single read port of the store, then
// coefficient, three multiplies on one shared multiplier with their adds,
// and output; the unit takes no new item until that read's result
// is in the output register. Reset empties the queue and the output register
// and leaves the store reading as zeros through its fill count. When the
// receiver stalls, a finished result holds in the output register, the unit
// then waits, and the input side stops once the queue is full.
// Depends on fdl_pkg, fdl_front, fdl_fifo and fdl_back.
module fractional_delay_line_cubic import fdl_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // sample_in, read_index, read_fraction
  input  logic [1:0]  s_axis_tuser_i,   // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // sample_out
);

  logic  push, full, pop, q_valid;
  item_t push_item, q_item;

  fdl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  fdl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  fdl_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fractional_delay_line_cubic: a ring-store model with a
// Catmull-Rom interpolator predicts every read result under random stalls.
// Depends on fdl_pkg and the design sources.
module tb_top;
  import fdl_pkg::*;

  localparam int unsigned AW          = $clog2(DefaultDepth);
  localparam logic [1:0]  CMD_NOP     = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = CMD_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  logic signed [15:0] line_mem [DefaultDepth];
  logic [AW-1:0]      line_wp;
  logic [15:0]        pending_out [$];
  int unsigned        error_count = 0;
  int unsigned        burst_left = 0;
  bit                 tx_steady = 1'b0;
  int unsigned        hold_req = 0;

  fractional_delay_line_cubic dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) begin
      $display("mismatch %0d at %0t: %s", error_count, $realtime, msg);
    end
  endtask

  function automatic void clear_line_model();
    for (int i = 0; i < DefaultDepth; i++) begin
      line_mem[i] = '0;
    end
    line_wp = '0;
  endfunction

  function automatic logic [15:0] catmull_rom_at(input logic [15:0] idx,
                                                 input logic [15:0] frac);
    logic [AW-1:0] a;
    longint h0, h1, h2, h3, c1, c2, c3, f, inner, mid, midr, acc, y;
    a  = idx[AW-1:0];
    h0 = longint'(line_mem[AW'(a - 1'b1)]);
    h1 = longint'(line_mem[a]);
    h2 = longint'(line_mem[AW'(a + 1'b1)]);
    h3 = longint'(line_mem[AW'(a + 2'd2)]);
    f  = longint'({48'd0, frac});
    c1 = h2 - h0;
    c2 = 2 * h0 - 5 * h1 + 4 * h2 - h3;
    c3 = 3 * (h1 - h2) + h3 - h0;
    inner = c2 * 65536 + c3 * f;
    mid   = c1 * 64'sd4294967296 + inner * f;
    midr  = (mid + 32768) >>> 16;
    acc   = midr * f;
    y     = h1 + ((acc + 64'sd4294967296) >>> 33);
    if (y > 32767) begin
      y = 32767;
    end else if (y < -32768) begin
      y = -32768;
    end
    return y[15:0];
  endfunction

  function automatic void track_item(input logic [1:0] cmd, input logic [15:0] sample,
                                     input logic [15:0] idx, input logic [15:0] frac);
    case (cmd)
      CMD_WRITE: begin
        line_mem[line_wp] = sample;
        line_wp = line_wp + 1'b1;
      end
      CMD_CLEAR: clear_line_model();
      CMD_READ:  pending_out.push_back(catmull_rom_at(idx, frac));
      default: ;
    endcase
  endfunction

  // One transfer on the input side; the model follows at the accepting edge.
  task automatic push_item(input logic [1:0] cmd, input logic [15:0] sample,
                           input logic [15:0] idx, input logic [15:0] frac);
    int unsigned gap;
    if (!tx_steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {frac, idx, sample};
    do @(posedge clk_i); while (!s_axis_tready);
    track_item(cmd, sample, idx, frac);
  endtask

  task automatic wait_results_drained();
    int unsigned n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    do begin
      @(posedge clk_i);
      n++;
    end while (pending_out.size() != 0 && n < DRAIN_LIMIT);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] recent_index(input int unsigned back);
    logic [15:0] ix;
    ix = 16'($urandom);
    ix[AW-1:0] = line_wp - AW'(back);
    return ix;
  endfunction

  task automatic test_directed_corners();
    push_item(CMD_READ, 16'h0000, 16'd0, 16'h0000);
    push_item(CMD_READ, 16'h0000, 16'hFFFF, 16'hFFFF);
    push_item(CMD_WRITE, 16'h7FFF, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h8000, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h0000, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h0001, 16'd0, 16'd0);
    push_item(CMD_READ, 16'h0000, 16'd0, 16'h0000);
    push_item(CMD_READ, 16'h0000, 16'd1, 16'hFFFF);
    push_item(CMD_READ, 16'h0000, 16'd0, 16'h8000);
    push_item(CMD_READ, 16'h0000, 16'(DefaultDepth - 1), 16'h4000);
    push_item(CMD_READ, 16'h0000, 16'hFFFF, 16'h0001);
    push_item(CMD_NOP, 16'h7FFF, 16'd1, 16'h8000);
    push_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(CMD_READ, 16'h0000, 16'd1, 16'h8000);
  endtask

  task automatic test_overshoot();
    push_item(CMD_WRITE, 16'h8000, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h7FFF, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h7FFF, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h8000, 16'd0, 16'd0);
    push_item(CMD_READ, 16'h0000, 16'd1, 16'h8000);
    push_item(CMD_WRITE, 16'h7FFF, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h8000, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h8000, 16'd0, 16'd0);
    push_item(CMD_WRITE, 16'h7FFF, 16'd0, 16'd0);
    push_item(CMD_READ, 16'h0000, 16'd5, 16'h8000);
    push_item(CMD_READ, 16'h0000, 16'd5, 16'hFFFF);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done, r, nw, nr;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        push_item(CMD_NOP, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 5) begin
        push_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        done++;
      end else if (r < 85) begin
        nw = $urandom_range(1, 8);
        nr = $urandom_range(1, 4);
        repeat (nw) push_item(CMD_WRITE, rand_sample(), 16'($urandom), 16'($urandom));
        repeat (nr) begin
          push_item(CMD_READ, 16'($urandom), recent_index($urandom_range(1, nw + 3)),
                    rand_frac());
        end
        done += nw + nr;
      end else if (r < 95) begin
        push_item(CMD_READ, 16'($urandom), 16'($urandom), rand_frac());
        done++;
      end else begin
        push_item(CMD_WRITE, rand_sample(), 16'($urandom), 16'($urandom));
        done++;
      end
    end
  endtask

  task automatic test_pointer_wrap();
    repeat (DefaultDepth + 6) begin
      push_item(CMD_WRITE, rand_sample(), 16'($urandom), 16'($urandom));
    end
    push_item(CMD_READ, 16'h0000, 16'd0, rand_frac());
    push_item(CMD_READ, 16'h0000, 16'(DefaultDepth - 1), rand_frac());
    push_item(CMD_READ, 16'h0000, 16'(DefaultDepth - 2), rand_frac());
    push_item(CMD_READ, 16'h0000, recent_index(1), rand_frac());
  endtask

  task automatic test_output_backpressure();
    hold_req <= hold_req + 1;
    tx_steady = 1'b1;
    repeat (24) begin
      push_item(CMD_READ, 16'($urandom), recent_index($urandom_range(1, 8)), rand_frac());
    end
    tx_steady = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_pause_and_resume();
    repeat (6) begin
      push_item(CMD_READ, 16'($urandom), recent_index($urandom_range(1, 8)), rand_frac());
    end
    wait_results_drained();
    push_item(CMD_WRITE, rand_sample(), 16'($urandom), 16'($urandom));
    push_item(CMD_READ, 16'($urandom), recent_index(1), rand_frac());
  endtask

  // Receiver: a long hold on request, otherwise changing stall patterns.
  always @(posedge clk_i) begin
    static int unsigned hold_seen = 0;
    static int unsigned hold_left = 0;
    static int unsigned mode = 0;
    static int unsigned mode_left = 0;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(1, 40);
      end
      mode_left--;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (mode_left % 7 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata !== want) begin
          report_mismatch($sformatf("sample_out got %h expected %h", m_axis_tdata, want));
        end
      end
    end
  end

  initial begin
    clear_line_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_overshoot();
    test_random_traffic(200);
    test_output_backpressure();
    test_pause_and_resume();
    test_pointer_wrap();
    test_random_traffic(220);
    wait_results_drained();
    repeat (40) @(posedge clk_i);
    if (pending_out.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_out.size()));
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/fdl_pkg.sv
design/fdl_front.sv
design/fdl_fifo.sv
design/fdl_back.sv
design/fractional_delay_line_cubic.sv
verif/tb_top.sv
